// File: design/fdea_pkg.sv
// ----------------------------------------------------------------------------
// fdea_pkg
// Shared types and constants of the file directory extent allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fdea_pkg;

  localparam int DIR_ENTRIES_DEF     = 32;
  localparam int MAP_BLOCKS_DEF      = 4096;
  localparam int EXTENT_BLOCKS_DEF   = 64;
  localparam int RESERVED_BLOCKS_DEF = 2;

  localparam int CMD_W    = 2;
  localparam int NAME_W   = 64;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;
  localparam int START_W  = 12;
  localparam int OUT_W    = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FORMAT = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_EXISTS   = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_NOSPACE  = 3'd3,
    STATUS_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR_RD,
    S_DIR_CHK,
    S_SCAN,
    S_MARK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    load_in;
    logic    fmt_clr;
    logic    clr_step;
    logic    dir_start;
    logic    dir_next;
    logic    dir_write;
    logic    dir_inval;
    logic    scan_start;
    logic    scan_step;
    logic    base_from_scan;
    logic    base_from_dir;
    logic    mark_step;
    logic    mark_val;
    logic    out_load;
    logic    out_with_loc;
    status_e out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dir_eq;
    logic dir_empty;
    logic dir_last;
    logic scan_found;
    logic scan_end;
    logic mark_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/fdea_ctrl.sv
// ----------------------------------------------------------------------------
// fdea_ctrl
// Controller that sequences directory search, map scan, marking and clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module fdea_ctrl import fdea_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  output logic             in_ready_o,
  input  dp_status_t       stat_i,
  output ctrl_cmd_t        cmd_o
);

  state_e  state_q, state_d;
  cmd_e    cmd_q, cmd_d;
  logic    fmt_q, fmt_d;
  status_e resp_q, resp_d;
  logic    loc_q, loc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cmd_q   <= CMD_CREATE;
      fmt_q   <= 1'b0;
      resp_q  <= STATUS_OK;
      loc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      fmt_q   <= fmt_d;
      resp_q  <= resp_d;
      loc_q   <= loc_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    cmd_d              = cmd_q;
    fmt_d              = fmt_q;
    resp_d             = resp_q;
    loc_d              = loc_q;
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    cmd_o.out_status   = resp_q;
    cmd_o.out_with_loc = loc_q;
    cmd_o.mark_val     = (cmd_q == CMD_CREATE);
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          fmt_d   = 1'b0;
          state_d = fmt_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cmd_d         = cmd_e'(in_cmd_i);
          resp_d        = STATUS_OK;
          loc_d         = 1'b0;
          case (cmd_e'(in_cmd_i))
            CMD_CREATE, CMD_DELETE: begin
              cmd_o.dir_start = 1'b1;
              state_d         = S_DIR_RD;
            end
            CMD_FORMAT: begin
              cmd_o.fmt_clr = 1'b1;
              fmt_d         = 1'b1;
              state_d       = S_CLEAR;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_DIR_RD: begin
        state_d = S_DIR_CHK;
      end
      S_DIR_CHK: begin
        if (cmd_q == CMD_CREATE) begin
          if (stat_i.dir_eq) begin
            resp_d  = STATUS_EXISTS;
            state_d = S_RESP;
          end else if (stat_i.dir_empty) begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end else if (stat_i.dir_last) begin
            resp_d  = STATUS_FULL;
            state_d = S_RESP;
          end else begin
            cmd_o.dir_next = 1'b1;
            state_d        = S_DIR_RD;
          end
        end else begin
          if (stat_i.dir_eq && !stat_i.dir_empty) begin
            cmd_o.base_from_dir = 1'b1;
            cmd_o.dir_inval     = 1'b1;
            state_d             = S_MARK;
          end else if (stat_i.dir_last) begin
            resp_d  = STATUS_NOTFOUND;
            state_d = S_RESP;
          end else begin
            cmd_o.dir_next = 1'b1;
            state_d        = S_DIR_RD;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_found) begin
          cmd_o.base_from_scan = 1'b1;
          state_d              = S_MARK;
        end else if (stat_i.scan_end) begin
          resp_d  = STATUS_NOSPACE;
          state_d = S_RESP;
        end
      end
      S_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (stat_i.mark_last) begin
          cmd_o.dir_write = (cmd_q == CMD_CREATE);
          resp_d          = STATUS_OK;
          loc_d           = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/fdea_datapath.sv
// ----------------------------------------------------------------------------
// fdea_datapath
// Directory memory, block free map, scan and mark counters, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdea_datapath import fdea_pkg::*; #(
  parameter int DIR_ENTRIES     = DIR_ENTRIES_DEF,
  parameter int MAP_BLOCKS      = MAP_BLOCKS_DEF,
  parameter int EXTENT_BLOCKS   = EXTENT_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          stat_o,
  input  logic [NAME_W-1:0]   in_name_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [SLOT_W-1:0]   out_slot_o,
  output logic [START_W-1:0]  out_start_o
);

  localparam int SW = $clog2(DIR_ENTRIES);
  localparam int BW = $clog2(MAP_BLOCKS);
  localparam int EW = $clog2(EXTENT_BLOCKS + 1);
  localparam int AW = ((BW > EW) ? BW : EW) + 1;

  localparam logic [AW-1:0] MapEnd    = AW'(MAP_BLOCKS);
  localparam logic [AW-1:0] ScanFirst = AW'(RESERVED_BLOCKS);
  localparam logic [AW-1:0] ExtM1     = AW'(EXTENT_BLOCKS - 1);
  localparam logic [EW-1:0] RunLast   = EW'(EXTENT_BLOCKS - 1);
  localparam logic [BW-1:0] ClrLast   = BW'(MAP_BLOCKS - 1);
  localparam logic [SW-1:0] DirLast   = SW'(DIR_ENTRIES - 1);
  localparam logic [SW-1:0] DirFirst  = SW'(1);

  logic [NAME_W-1:0] dir_name_mem [DIR_ENTRIES];
  logic [BW-1:0]     dir_start_mem [DIR_ENTRIES];
  logic              map_mem [MAP_BLOCKS];

  logic [DIR_ENTRIES-1:0] dir_valid_q;
  logic [SW-1:0]          dir_idx_q;
  logic [NAME_W-1:0]      name_q;
  logic [NAME_W-1:0]      dir_name_rd_q;
  logic [BW-1:0]          dir_start_rd_q;
  logic                   dir_vrd_q;

  logic [AW-1:0] scan_addr_q;
  logic [AW-1:0] chk_addr_q;
  logic          chk_vld_q;
  logic [EW-1:0] run_q;
  logic          map_rdata_q;
  logic [BW-1:0] base_q;
  logic [EW-1:0] mark_cnt_q;
  logic [BW-1:0] clr_addr_q;

  logic [AW-1:0] mark_addr;
  logic          map_we;
  logic [BW-1:0] map_waddr;
  logic          map_wdata;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [START_W-1:0]  out_start_q;

  assign mark_addr = AW'(base_q) + AW'(mark_cnt_q);

  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_addr_q;
    map_wdata = 1'b0;
    if (cmd_i.clr_step) begin
      map_we = 1'b1;
    end else if (cmd_i.mark_step) begin
      map_we    = (mark_addr < MapEnd);
      map_waddr = mark_addr[BW-1:0];
      map_wdata = cmd_i.mark_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata_q <= map_mem[scan_addr_q[BW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dir_write) begin
      dir_name_mem[dir_idx_q]  <= name_q;
      dir_start_mem[dir_idx_q] <= base_q;
    end
    dir_name_rd_q  <= dir_name_mem[dir_idx_q];
    dir_start_rd_q <= dir_start_mem[dir_idx_q];
    dir_vrd_q      <= dir_valid_q[dir_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_valid_q <= '0;
      dir_idx_q   <= '0;
      clr_addr_q  <= '0;
      scan_addr_q <= '0;
      chk_vld_q   <= 1'b0;
      run_q       <= '0;
      mark_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.fmt_clr) begin
        dir_valid_q <= '0;
      end else if (cmd_i.dir_write) begin
        dir_valid_q[dir_idx_q] <= 1'b1;
      end else if (cmd_i.dir_inval) begin
        dir_valid_q[dir_idx_q] <= 1'b0;
      end
      if (cmd_i.dir_start) begin
        dir_idx_q <= DirFirst;
      end else if (cmd_i.dir_next) begin
        dir_idx_q <= dir_idx_q + SW'(1);
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= (clr_addr_q == ClrLast) ? '0 : clr_addr_q + BW'(1);
      end
      if (cmd_i.scan_start) begin
        scan_addr_q <= ScanFirst;
        chk_vld_q   <= 1'b0;
        run_q       <= '0;
      end else if (cmd_i.scan_step) begin
        chk_vld_q <= (scan_addr_q < MapEnd);
        if (scan_addr_q < MapEnd) begin
          scan_addr_q <= scan_addr_q + AW'(1);
        end
        if (chk_vld_q) begin
          run_q <= map_rdata_q ? '0 : run_q + EW'(1);
        end
      end
      if (cmd_i.base_from_scan || cmd_i.base_from_dir) begin
        mark_cnt_q <= '0;
      end else if (cmd_i.mark_step) begin
        mark_cnt_q <= mark_cnt_q + EW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      name_q <= in_name_i;
    end
    if (cmd_i.scan_step) begin
      chk_addr_q <= scan_addr_q;
    end
    if (cmd_i.base_from_scan) begin
      base_q <= BW'(chk_addr_q - ExtM1);
    end else if (cmd_i.base_from_dir) begin
      base_q <= dir_start_rd_q;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_slot_q   <= cmd_i.out_with_loc ? SLOT_W'(dir_idx_q) : '0;
      out_start_q  <= cmd_i.out_with_loc ? START_W'(base_q) : '0;
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.clr_last   = (clr_addr_q == ClrLast);
    stat_o.dir_eq     = ((dir_vrd_q ? dir_name_rd_q : '0) == name_q);
    stat_o.dir_empty  = !dir_vrd_q;
    stat_o.dir_last   = (dir_idx_q == DirLast);
    stat_o.scan_found = chk_vld_q && !map_rdata_q && (run_q == RunLast);
    stat_o.scan_end   = !chk_vld_q && (scan_addr_q == MapEnd);
    stat_o.mark_last  = (mark_cnt_q == RunLast);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_start_o  = out_start_q;

endmodule

`default_nettype wire

// File: design/file_directory_extent_allocator_unit.sv
// ----------------------------------------------------------------------------
// file_directory_extent_allocator_unit
// Named file directory with first-fit contiguous extent allocation.
//
// Channel   Direction  Payload
// s_axis    in         tuser[1:0] cmd, tdata[63:0] fname
// m_axis    out        tdata[2:0] status, [7:3] slot, [19:8] first_blk
//
// Create examines directory slots in turn, scans the map from block
// RESERVED_BLOCKS for a free run, marks the extent and loads the result register.
// Delete examines slots in turn and then frees the extent.
// Format and reset each run a clearing pass over the whole map.
// The result register holds while m_axis_tready is low; the next item is
// taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module file_directory_extent_allocator_unit import fdea_pkg::*; #(
  parameter int DIR_ENTRIES     = DIR_ENTRIES_DEF,
  parameter int MAP_BLOCKS      = MAP_BLOCKS_DEF,
  parameter int EXTENT_BLOCKS   = EXTENT_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // fname[63:0]
  input  logic [NAME_W-1:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]  s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status[2:0], slot[7:3], first_blk[19:8], zero[23:20]
  output logic [OUT_W-1:0]  m_axis_tdata
);

  ctrl_cmd_t           cmd;
  dp_status_t          stat;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [START_W-1:0]  out_start;

  fdea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fdea_datapath #(
    .DIR_ENTRIES     (DIR_ENTRIES),
    .MAP_BLOCKS      (MAP_BLOCKS),
    .EXTENT_BLOCKS   (EXTENT_BLOCKS),
    .RESERVED_BLOCKS (RESERVED_BLOCKS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_name_i    (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_slot_o   (out_slot),
    .out_start_o  (out_start)
  );

  assign m_axis_tdata = {
    (OUT_W - START_W - SLOT_W - STATUS_W)'(0), out_start, out_slot, out_status
  };

endmodule

`default_nettype wire

// File: design/fdea_checker.sv
// ----------------------------------------------------------------------------
// fdea_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fdea_checker import fdea_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_q, pending_d;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign pending_d = pending_q + {1'b0, in_acc} - {1'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 2'd0)
    else $error("result delivered without an accepted item");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many items outstanding");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("item taken while the previous one is still at work");

endmodule

bind file_directory_extent_allocator_unit fdea_checker u_fdea_checker (.*);

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the file directory extent allocator.
//
// Commands go in on the slave stream and answers come back on the master
// stream. A scoreboard keeps its own copy of the directory and the block
// map. It works out the answer to each accepted command and compares the
// answers in order, field by field. A short directed sequence comes first.
// Random traffic follows over a small pool of names, with one burst that
// fills the directory. Both sides idle at random. One long receiver
// hold-off backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fdea_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int POOL_SIZE = 24;
  localparam int RANDOM_ITEMS = 120;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 4400;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [START_W-1:0]  start;
  } dir_answer_t;

  class extent_dir_scoreboard;
    logic [NAME_W-1:0]  names  [DIR_ENTRIES_DEF];
    logic [START_W-1:0] starts [DIR_ENTRIES_DEF];
    bit                 busy   [MAP_BLOCKS_DEF];
    dir_answer_t        answers_due[$];
    int                 errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (names[i]) begin
        names[i] = '0;
        starts[i] = '0;
      end
      foreach (busy[i]) busy[i] = 1'b0;
    endfunction

    function bit find_extent(output int base_blk);
      int b;
      int off;
      bit clear;
      b = RESERVED_BLOCKS_DEF;
      base_blk = 0;
      while (b + EXTENT_BLOCKS_DEF <= MAP_BLOCKS_DEF) begin
        clear = 1'b1;
        for (off = 0; off < EXTENT_BLOCKS_DEF; off++) begin
          if (busy[b + off]) begin
            clear = 1'b0;
            break;
          end
        end
        if (clear) begin
          base_blk = b;
          return 1'b1;
        end
        b = b + off + 1;
      end
      return 1'b0;
    endfunction

    function void set_extent(int base_blk, bit val);
      for (int k = 0; k < EXTENT_BLOCKS_DEF; k++) begin
        if (base_blk + k < MAP_BLOCKS_DEF) busy[base_blk + k] = val;
      end
    endfunction

    function void note_command(logic [CMD_W-1:0] c, logic [NAME_W-1:0] n);
      dir_answer_t r;
      int s;
      int free_slot;
      int b;
      bit hit;
      bit have_free;
      r.status = STATUS_OK;
      r.slot = '0;
      r.start = '0;
      hit = 1'b0;
      have_free = 1'b0;
      free_slot = 0;
      case (c)
        CMD_CREATE: begin
          for (s = 1; s < DIR_ENTRIES_DEF; s++) begin
            if (names[s] == n) begin
              hit = 1'b1;
              break;
            end
            if (names[s] == '0) begin
              free_slot = s;
              have_free = 1'b1;
              break;
            end
          end
          if (hit) begin
            r.status = STATUS_EXISTS;
          end else if (!have_free) begin
            r.status = STATUS_FULL;
          end else if (!find_extent(b)) begin
            r.status = STATUS_NOSPACE;
          end else begin
            set_extent(b, 1'b1);
            names[free_slot] = n;
            starts[free_slot] = START_W'(b);
            r.slot = SLOT_W'(free_slot);
            r.start = START_W'(b);
          end
        end
        CMD_DELETE: begin
          if (n != '0) begin
            for (s = 1; s < DIR_ENTRIES_DEF; s++) begin
              if (names[s] == n) begin
                hit = 1'b1;
                break;
              end
            end
          end
          if (!hit) begin
            r.status = STATUS_NOTFOUND;
          end else begin
            r.start = starts[s];
            set_extent(int'(starts[s]), 1'b0);
            names[s] = '0;
            starts[s] = '0;
            r.slot = SLOT_W'(s);
          end
        end
        CMD_FORMAT: begin
          wipe();
        end
        default: begin
        end
      endcase
      answers_due.push_back(r);
    endfunction

    function void check_answer(logic [OUT_W-1:0] d);
      dir_answer_t e;
      logic [STATUS_W-1:0] got_status;
      logic [SLOT_W-1:0]   got_slot;
      logic [START_W-1:0]  got_start;
      got_status = d[2:0];
      got_slot = d[7:3];
      got_start = d[19:8];
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: status %0d slot %0d start %0d",
                   got_status, got_slot, got_start);
        return;
      end
      e = answers_due.pop_front();
      if (got_status !== e.status || got_slot !== e.slot || got_start !== e.start) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d slot %0d start %0d, got %0d %0d %0d",
                   e.status, e.slot, e.start, got_status, got_slot, got_start);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [NAME_W-1:0] s_axis_tdata;
  logic [CMD_W-1:0]  s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;

  extent_dir_scoreboard sb = new();
  logic [NAME_W-1:0]    name_pool [POOL_SIZE];
  bit                   calm;
  bit                   hold_req;
  bit                   hold_done;
  int                   hold_left;

  file_directory_extent_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function bit want_idle();
    return !calm && ($urandom_range(99) < 32);
  endfunction

  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !want_idle();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_answer(m_axis_tdata);
  end

  task automatic issue_command(input logic [CMD_W-1:0] c, input logic [NAME_W-1:0] n);
    while (want_idle()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= n;
    s_axis_tuser <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_command(c, n);
    @(negedge clk_i);
  endtask

  task automatic issue_random_op();
    int r;
    logic [NAME_W-1:0] fresh;
    r = $urandom_range(99);
    fresh = ($urandom_range(7) == 0) ? '0 : {$urandom, $urandom};
    if (r < 45)
      issue_command(CMD_CREATE, name_pool[$urandom_range(POOL_SIZE - 1)]);
    else if (r < 80)
      issue_command(CMD_DELETE, name_pool[$urandom_range(POOL_SIZE - 1)]);
    else if (r < 88)
      issue_command(CMD_CREATE, fresh);
    else if (r < 94)
      issue_command(CMD_DELETE, fresh);
    else if (r < 97)
      issue_command(CMD_FORMAT, fresh);
    else
      issue_command(CMD_UNUSED, fresh);
  endtask

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_CREATE;
    calm = 1'b0;
    hold_req = 1'b0;
    foreach (name_pool[i]) name_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue_command(CMD_CREATE, '0);
    issue_command(CMD_DELETE, '0);
    issue_command(CMD_DELETE, 64'h414C_5048_4100_0000);
    issue_command(CMD_CREATE, '1);
    issue_command(CMD_CREATE, 64'h414C_5048_4100_0000);
    issue_command(CMD_CREATE, 64'h1);
    issue_command(CMD_CREATE, 64'h414C_5048_4100_0000);
    issue_command(CMD_UNUSED, 64'h414C_5048_4100_0000);
    issue_command(CMD_DELETE, 64'h414C_5048_4100_0000);
    issue_command(CMD_CREATE, 64'h1);
    issue_command(CMD_CREATE, 64'h4245_5441_0000_0000);
    issue_command(CMD_DELETE, 64'h1);
    issue_command(CMD_DELETE, 64'h1);
    issue_command(CMD_DELETE, 64'h1);
    issue_command(CMD_FORMAT, '0);
    issue_command(CMD_DELETE, '1);
    issue_command(CMD_CREATE, 64'h8000_0000_0000_0000);
    issue_command(CMD_CREATE, '1);
    issue_command(CMD_DELETE, 64'h8000_0000_0000_0000);
    issue_command(CMD_UNUSED, '1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 10) hold_req = 1'b1;
      calm = (i >= 88 && i < 118);
      if (i >= 45 && i < 80)
        issue_command(CMD_CREATE, {$urandom, $urandom});
      else
        issue_random_op();
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (sb.answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
